@@ rtl/swalk_pkg.sv @@
// shared types and constants for the sv39 page table walker
package swalk_pkg;

  localparam int unsigned PaW       = 56;
  localparam int unsigned VaW       = 39;
  localparam int unsigned PteW      = 64;
  localparam int unsigned PpnW      = 44;
  localparam int unsigned VpnW      = 9;
  localparam int unsigned PgOffW    = 12;
  localparam int unsigned PteDirty  = 7;
  localparam int unsigned OutqDepth = 4;
  localparam int unsigned OutqPtrW  = $clog2(OutqDepth);
  localparam int unsigned OutqCntW  = $clog2(OutqDepth + 1);

  localparam logic OP_XLATE = 1'b0;
  localparam logic OP_PTE   = 1'b1;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DONE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    LVL_0 = 2'd0,
    LVL_1 = 2'd1,
    LVL_2 = 2'd2,
    LVL_X = 2'd3
  } level_e;

  typedef struct packed {
    kind_e             kind;
    logic [PaW-1:0]    mem_addr;
    logic [PteW-1:0]   write_data;
    logic [PaW-1:0]    phys_addr;
    logic              fault;
    logic              last;
  } res_t;

  typedef struct packed {
    logic       push0;
    logic       push1;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

@@ rtl/swalk_cfg.sv @@
// apb register holding the root page number
module swalk_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  output logic [swalk_pkg::PpnW-1:0]  root_ppn_o
);
  import swalk_pkg::*;

  logic [PpnW-1:0] root_ppn_q;
  logic            hit;

  assign hit    = (paddr[3] == 1'b0);
  assign pready = 1'b1;
  assign prdata = hit ? {{(64-PpnW){1'b0}}, root_ppn_q} : 64'd0;
  assign root_ppn_o = root_ppn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_ppn_q <= '0;
    end else if (psel && penable && pwrite && pready && hit) begin
      root_ppn_q <= pwdata[PpnW-1:0];
    end
  end

endmodule

@@ rtl/swalk_core.sv @@
// input register, walk state and per-request result logic
module swalk_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [swalk_pkg::VaW-1:0]   virt_addr_i,
  input  logic [swalk_pkg::PteW-1:0]  pte_data_i,
  input  logic [swalk_pkg::PpnW-1:0]  root_ppn_i,
  input  logic                        room_i,
  output swalk_pkg::push_t            push_o
);
  import swalk_pkg::*;

  logic              in_vld_q;
  logic              op_q;
  logic [VaW-1:0]    va_q;
  logic [PteW-1:0]   pte_q;

  logic              busy_q, busy_d;
  level_e            level_q, level_d;
  logic [VaW-1:0]    saved_va_q, saved_va_d;
  logic [PaW-1:0]    entry_addr_q, entry_addr_d;

  logic              adv;
  logic              accept;
  logic [PaW-1:0]    ppn_sh;
  logic [PaW-1:0]    low_mask;
  logic [PaW-1:0]    va_ext;
  logic [VpnW-1:0]   next_vpn;
  logic              is_leaf;
  push_t             push;

  assign adv        = in_vld_q && room_i;
  assign in_stall_o = in_vld_q && !room_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign ppn_sh  = {pte_q[PaW-PgOffW+9:10], {PgOffW{1'b0}}};
  assign va_ext  = {{(PaW-VaW){1'b0}}, saved_va_q};
  assign is_leaf = (pte_q[3:1] != 3'b000) || (level_q == LVL_0);

  always_comb begin
    case (level_q)
      LVL_0:   low_mask = {{(PaW-12){1'b0}}, {12{1'b1}}};
      LVL_1:   low_mask = {{(PaW-21){1'b0}}, {21{1'b1}}};
      LVL_2:   low_mask = {{(PaW-30){1'b0}}, {30{1'b1}}};
      default: low_mask = {{(PaW-39){1'b0}}, {39{1'b1}}};
    endcase
  end

  always_comb begin
    case (level_q)
      LVL_2:   next_vpn = saved_va_q[29:21];
      default: next_vpn = saved_va_q[20:12];
    endcase
  end

  always_comb begin
    push         = '0;
    push.r0.kind = KIND_READ;
    push.r1.kind = KIND_READ;
    busy_d       = busy_q;
    level_d      = level_q;
    saved_va_d   = saved_va_q;
    entry_addr_d = entry_addr_q;
    if (adv) begin
      if (op_q == OP_XLATE) begin
        if (!busy_q) begin
          saved_va_d       = va_q;
          level_d          = LVL_2;
          entry_addr_d     = {root_ppn_i, va_q[38:30], 3'b000};
          busy_d           = 1'b1;
          push.push0       = 1'b1;
          push.r0.kind     = KIND_READ;
          push.r0.mem_addr = entry_addr_d;
          push.r0.last     = 1'b1;
        end
      end else if (busy_q) begin
        if (!pte_q[0]) begin
          busy_d        = 1'b0;
          push.push0    = 1'b1;
          push.r0.kind  = KIND_DONE;
          push.r0.fault = 1'b1;
          push.r0.last  = 1'b1;
        end else if (is_leaf) begin
          busy_d             = 1'b0;
          push.push0         = 1'b1;
          push.r0.kind       = KIND_WRITE;
          push.r0.mem_addr   = entry_addr_q;
          push.r0.write_data = pte_q;
          push.r0.write_data[PteDirty] = 1'b1;
          push.push1         = 1'b1;
          push.r1.kind       = KIND_DONE;
          push.r1.phys_addr  = (va_ext & low_mask) | (ppn_sh & ~low_mask);
          push.r1.last       = 1'b1;
        end else begin
          level_d          = (level_q == LVL_2) ? LVL_1 : LVL_0;
          entry_addr_d     = {ppn_sh[PaW-1:PgOffW], next_vpn, 3'b000};
          push.push0       = 1'b1;
          push.r0.kind     = KIND_READ;
          push.r0.mem_addr = entry_addr_d;
          push.r0.last     = 1'b1;
        end
      end
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      busy_q       <= 1'b0;
      level_q      <= LVL_0;
      saved_va_q   <= '0;
      entry_addr_q <= '0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      busy_q       <= busy_d;
      level_q      <= level_d;
      saved_va_q   <= saved_va_d;
      entry_addr_q <= entry_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      va_q  <= virt_addr_i;
      pte_q <= pte_data_i;
    end
  end

endmodule

@@ rtl/swalk_outq.sv @@
// small result queue taking up to two results per cycle
module swalk_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  swalk_pkg::push_t push_i,
  output logic             room_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output swalk_pkg::res_t  head_o
);
  import swalk_pkg::*;

  res_t                mem_q [OutqDepth];
  logic [OutqPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OutqCntW-1:0] cnt_q;
  logic [OutqPtrW-1:0] wr_ptr_nx;
  logic                pop;
  logic [1:0]          n_push;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (cnt_q <= OutqCntW'(OutqDepth - 2));
  assign head_o      = mem_q[rd_ptr_q];
  assign wr_ptr_nx   = wr_ptr_q + OutqPtrW'(1);
  assign n_push      = {1'b0, push_i.push0} + {1'b0, push_i.push1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + OutqPtrW'(n_push);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OutqPtrW'(1);
      end
      cnt_q <= cnt_q + OutqCntW'(n_push) - OutqCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.push1) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

endmodule

@@ rtl/sv39_page_walker.sv @@
// top level of the sv39 page table walker
// Takes one request per cycle while not stalled (translate or returned page
// table entry) into an input register; its walk step is resolved from that
// register once the result queue has room; its results land in a four-entry
// result queue whose head drives the output. A leaf entry yields two results
// (the dirty write-back, then the done result) which drain one per cycle while
// the output is not stalled; every other request yields one or none. The input
// stalls only while the result queue holds more than two results, so sustained
// rate is one request per cycle, bounded by the output side taking one result
// per cycle. Walk throughput is set by the memory latency of the entry reads.
// root_ppn lies at byte address 0 of the apb port.
module sv39_page_walker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [swalk_pkg::VaW-1:0]   virt_addr_i,
  input  logic [swalk_pkg::PteW-1:0]  pte_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic [swalk_pkg::PaW-1:0]   mem_addr_o,
  output logic [swalk_pkg::PteW-1:0]  write_data_o,
  output logic [swalk_pkg::PaW-1:0]   phys_addr_o,
  output logic                        fault_o,
  output logic                        last_o
);
  import swalk_pkg::*;

  logic [PpnW-1:0] root_ppn;
  logic            room;
  push_t           push;
  res_t            head;

  swalk_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .root_ppn_o (root_ppn)
  );

  swalk_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .virt_addr_i (virt_addr_i),
    .pte_data_i  (pte_data_i),
    .root_ppn_i  (root_ppn),
    .room_i      (room),
    .push_o      (push)
  );

  swalk_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign kind_o       = head.kind;
  assign mem_addr_o   = head.mem_addr;
  assign write_data_o = head.write_data;
  assign phys_addr_o  = head.phys_addr;
  assign fault_o      = head.fault;
  assign last_o       = head.last;

endmodule
